FILE: hw/rtl/riff_chunk_size_checker_defines.svh
// ----------------------------------------------------------------------------
// riff_chunk_size_checker_defines.svh
// Assertion macros shared by the RIFF chunk size checker modules.
// ----------------------------------------------------------------------------
`ifndef RIFF_CHUNK_SIZE_CHECKER_DEFINES_SVH
`define RIFF_CHUNK_SIZE_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define RCSC_ASSERT_IMM(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define RCSC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rcsc_pkg.sv
// ----------------------------------------------------------------------------
// rcsc_pkg
// Types and constants of the RIFF/RF64 chunk size checker.
// ----------------------------------------------------------------------------
package rcsc_pkg;

  localparam int unsigned CFG_LEN_W  = 48;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [3:0]  HDR_START   = 4'd12;
  localparam logic [3:0]  HDR_LEN     = 4'd8;
  localparam logic [31:0] DS64_PREFIX = 32'd28;
  localparam logic [31:0] ID_DS64     = 32'h6473_3634;
  localparam logic [31:0] ID_DATA     = 32'h6461_7461;

  typedef enum logic [0:0] {
    REG_FILE_LENGTH = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_HEADER = 3'b010,
    PH_PREFIX = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    V_NONE    = 3'd0,
    V_OK      = 3'd1,
    V_OVERRUN = 3'd2,
    V_TABLE   = 3'd3,
    V_RAGGED  = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    CAUSE_OK      = 2'd0,
    CAUSE_OVERRUN = 2'd1,
    CAUSE_TABLE   = 2'd2,
    CAUSE_RAGGED  = 2'd3
  } cause_e;

  typedef struct packed {
    cause_e cause;
    logic   refused;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } res_msg_t;

  function automatic cause_e verdict_cause(verdict_e v);
    cause_e c;
    case (v)
      V_OVERRUN: c = CAUSE_OVERRUN;
      V_TABLE:   c = CAUSE_TABLE;
      V_RAGGED:  c = CAUSE_RAGGED;
      default:   c = CAUSE_OK;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/rcsc_regs.sv
// ----------------------------------------------------------------------------
// rcsc_regs
// APB register file holding the file length.
// ----------------------------------------------------------------------------
module rcsc_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcsc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rcsc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rcsc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [rcsc_pkg::CFG_LEN_W-1:0]      file_length_o
);

  logic [rcsc_pkg::CFG_LEN_W-1:0] file_length_q;
  rcsc_pkg::reg_idx_e             reg_idx;
  logic                           wr_en;

  // Registers sit 8 bytes apart; the low address bits are ignored.
  assign reg_idx = rcsc_pkg::reg_idx_e'(paddr[rcsc_pkg::APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite && pready
                   && (reg_idx == rcsc_pkg::REG_FILE_LENGTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (wr_en) begin
      file_length_q <= pwdata[rcsc_pkg::CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcsc_pkg::REG_FILE_LENGTH: prdata = rcsc_pkg::APB_DATA_W'(file_length_q);
      default:                   prdata = '0;
    endcase
  end

  assign file_length_o = file_length_q;

endmodule

FILE: hw/rtl/rcsc_walker.sv
// ----------------------------------------------------------------------------
// rcsc_walker
// Input register and chunk table walk: one byte per cycle, unless a last byte
// waits on the result register, updates the offset, header shift registers,
// ds64 capture and the latched verdict.
`include "riff_chunk_size_checker_defines.svh"

module rcsc_walker #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rcsc_pkg::CFG_LEN_W-1:0]    file_length_i,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [7:0]                        s_byte_i,
  input  logic                              s_last_i,
  input  logic                              out_free_i,
  output rcsc_pkg::res_msg_t                res_o
);

  localparam int unsigned OFF_W  = OFFSET_BITS + 1;
  localparam int unsigned CMP_W  = OFFSET_BITS + 2;
  localparam int unsigned WIDE_W = (CMP_W > 64) ? CMP_W : 64;
  localparam logic [OFF_W-1:0] POS_MAX = '1;

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       proc;

  // Walk state.
  logic [OFF_W-1:0]     pos_q, pos_d;
  logic [OFF_W-1:0]     nha_q, nha_d;
  rcsc_pkg::phase_e     phase_q, phase_d;
  logic [4:0]           k_q, k_d;
  logic [31:0]          id_q, id_d;
  logic [31:0]          size_q, size_d;
  logic [63:0]          prefix_q, prefix_d;
  logic [63:0]          ds64_q, ds64_d;
  logic                 seen_q, seen_d;
  rcsc_pkg::verdict_e   verdict_q, verdict_d;

  // Datapath terms.
  logic [CMP_W-1:0]     flen, flen_m8;
  logic                 flen_short, short_file, skip_short;
  logic                 in_prefix, hdr_start;
  logic [2:0]           hdr_k;
  logic [31:0]          id_base, size_base, id_new, size_new;
  logic [CMP_W-1:0]     fin_end, room, fin_len, fin_next;
  logic [31:0]          fin_decl;
  logic                 past, over, resize_ok, ds64_cand;
  rcsc_pkg::verdict_e   fin_verdict;
  logic [63:0]          prefix_new;
  logic                 in_len_field, in_tab_field;
  logic [31:0]          table_room;
  logic [35:0]          table_need;
  logic                 table_bad;
  logic                 hdr_go;
  rcsc_pkg::verdict_e   final_v;

  assign proc      = in_valid_q && (!last_q || out_free_i);
  assign s_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= s_byte_i;
      last_q <= s_last_i;
    end
  end

  // Only the low OFFSET_BITS bits of the length take part.
  if (OFFSET_BITS < rcsc_pkg::CFG_LEN_W) begin : g_len_cut
    assign flen = CMP_W'(file_length_i[OFFSET_BITS-1:0]);
  end else begin : g_len_full
    assign flen = CMP_W'(file_length_i);
  end

  assign flen_short = flen < CMP_W'(rcsc_pkg::HDR_LEN);
  assign flen_m8    = flen - CMP_W'(rcsc_pkg::HDR_LEN);
  assign short_file = flen < CMP_W'(rcsc_pkg::HDR_START);
  // A header at nha needs eight bytes inside the file: nha + 8 > len.
  assign skip_short = flen_short || (CMP_W'(nha_q) > flen_m8);

  // Header assembly; a header starting this cycle begins from empty shifts.
  assign hdr_start = (phase_q == rcsc_pkg::PH_SKIP);
  assign in_prefix = (phase_q == rcsc_pkg::PH_PREFIX);
  assign hdr_k     = hdr_start ? 3'd0 : k_q[2:0];
  assign id_base   = hdr_start ? '0 : id_q;
  assign size_base = hdr_start ? '0 : size_q;
  assign id_new    = {id_base[23:0], byte_q};
  assign size_new  = size_base | (32'(byte_q) << {hdr_k[1:0], 3'b000});

  // Chunk end check, shared by the plain header and the ds64 prefix end.
  assign fin_end  = in_prefix ? CMP_W'(nha_q) : CMP_W'(pos_q) + CMP_W'(1);
  assign fin_decl = in_prefix ? size_q : size_new;
  assign past     = fin_end > flen;
  assign room     = flen - fin_end;
  assign over     = past || (WIDE_W'(fin_decl) > WIDE_W'(room));
  assign resize_ok = seen_q && !past && !(WIDE_W'(ds64_q) > WIDE_W'(room));

  always_comb begin
    if (!over) begin
      fin_verdict = rcsc_pkg::V_NONE;
    end else if (id_q != rcsc_pkg::ID_DATA) begin
      fin_verdict = rcsc_pkg::V_OVERRUN;
    end else if (!resize_ok) begin
      fin_verdict = rcsc_pkg::V_OK;
    end else begin
      fin_verdict = rcsc_pkg::V_NONE;
    end
  end

  // An oversized data chunk takes its length from ds64 instead.
  assign fin_len  = over ? CMP_W'(ds64_q) : CMP_W'(fin_decl);
  assign fin_next = fin_end + fin_len + CMP_W'(fin_len[0]);

  assign ds64_cand = (id_q == rcsc_pkg::ID_DS64) && !seen_q
                     && (size_new >= rcsc_pkg::DS64_PREFIX) && !over;

  // ds64 prefix: bytes 8..15 hold the data size, bytes 24..27 the table length.
  assign prefix_new   = prefix_q | (64'(byte_q) << {k_q[2:0], 3'b000});
  assign in_len_field = (k_q[4:3] == 2'b01);
  assign in_tab_field = (k_q[4:3] == 2'b11) && !k_q[2];
  assign table_room   = size_q - rcsc_pkg::DS64_PREFIX;
  assign table_need   = {1'b0, prefix_new[31:0], 3'b000}
                        + {2'b00, prefix_new[31:0], 2'b00};
  assign table_bad    = 36'(table_room) < table_need;

  always_comb begin
    pos_d     = pos_q;
    nha_d     = nha_q;
    phase_d   = phase_q;
    k_d       = k_q;
    id_d      = id_q;
    size_d    = size_q;
    prefix_d  = prefix_q;
    ds64_d    = ds64_q;
    seen_d    = seen_q;
    verdict_d = verdict_q;
    hdr_go    = 1'b0;
    final_v   = rcsc_pkg::V_OK;
    res_o     = '0;

    if (proc) begin
      pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + OFF_W'(1);

      if (verdict_q == rcsc_pkg::V_NONE) begin
        unique case (phase_q)
          rcsc_pkg::PH_SKIP: begin
            if (pos_q == nha_q) begin
              if (skip_short) begin
                verdict_d = (CMP_W'(nha_q) >= flen) ? rcsc_pkg::V_OK : rcsc_pkg::V_RAGGED;
              end else begin
                hdr_go = 1'b1;
              end
            end
          end
          rcsc_pkg::PH_HEADER: begin
            hdr_go = 1'b1;
          end
          rcsc_pkg::PH_PREFIX: begin
            k_d = k_q + 5'd1;
            if (in_len_field) begin
              prefix_d = prefix_new;
              if (k_q[2:0] == 3'd7) begin
                ds64_d   = prefix_new;
                seen_d   = 1'b1;
                prefix_d = '0;
              end
            end else if (in_tab_field) begin
              prefix_d = prefix_new;
              if (k_q[1:0] == 2'd3) begin
                if (table_bad) begin
                  verdict_d = rcsc_pkg::V_TABLE;
                end else if (fin_verdict != rcsc_pkg::V_NONE) begin
                  verdict_d = fin_verdict;
                end else begin
                  nha_d   = OFF_W'(fin_next);
                  phase_d = rcsc_pkg::PH_SKIP;
                end
              end
            end
          end
          default: begin
            verdict_d = rcsc_pkg::V_OK;
          end
        endcase

        if (hdr_go) begin
          phase_d = rcsc_pkg::PH_HEADER;
          k_d     = 5'(hdr_k) + 5'd1;
          id_d    = hdr_k[2] ? id_base : id_new;
          size_d  = hdr_k[2] ? size_new : size_base;
          if (hdr_k == 3'd7) begin
            if (ds64_cand) begin
              nha_d    = OFF_W'(fin_end);
              prefix_d = '0;
              phase_d  = rcsc_pkg::PH_PREFIX;
              k_d      = '0;
            end else if (fin_verdict != rcsc_pkg::V_NONE) begin
              verdict_d = fin_verdict;
            end else begin
              nha_d   = OFF_W'(fin_next);
              phase_d = rcsc_pkg::PH_SKIP;
            end
          end
        end
      end

      if (last_q) begin
        // An undecided walk that ends waiting on a header close to the file
        // end is ragged unless that header lies at or past the end.
        if (short_file) begin
          final_v = rcsc_pkg::V_OK;
        end else if (verdict_d != rcsc_pkg::V_NONE) begin
          final_v = verdict_d;
        end else if ((phase_d == rcsc_pkg::PH_SKIP)
                     && (flen_short || (CMP_W'(nha_d) > flen_m8))) begin
          final_v = (CMP_W'(nha_d) >= flen) ? rcsc_pkg::V_OK : rcsc_pkg::V_RAGGED;
        end else begin
          final_v = rcsc_pkg::V_OK;
        end
        res_o.valid          = 1'b1;
        res_o.result.refused = (final_v != rcsc_pkg::V_OK);
        res_o.result.cause   = rcsc_pkg::verdict_cause(final_v);

        pos_d     = '0;
        nha_d     = OFF_W'(rcsc_pkg::HDR_START);
        phase_d   = rcsc_pkg::PH_SKIP;
        k_d       = '0;
        id_d      = '0;
        size_d    = '0;
        prefix_d  = '0;
        ds64_d    = '0;
        seen_d    = 1'b0;
        verdict_d = rcsc_pkg::V_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      nha_q     <= OFF_W'(rcsc_pkg::HDR_START);
      phase_q   <= rcsc_pkg::PH_SKIP;
      k_q       <= '0;
      id_q      <= '0;
      size_q    <= '0;
      prefix_q  <= '0;
      ds64_q    <= '0;
      seen_q    <= 1'b0;
      verdict_q <= rcsc_pkg::V_NONE;
    end else begin
      pos_q     <= pos_d;
      nha_q     <= nha_d;
      phase_q   <= phase_d;
      k_q       <= k_d;
      id_q      <= id_d;
      size_q    <= size_d;
      prefix_q  <= prefix_d;
      ds64_q    <= ds64_d;
      seen_q    <= seen_d;
      verdict_q <= verdict_d;
    end
  end

  `RCSC_ASSERT_NXT(a_clear_after_last, proc && last_q,
    pos_q == '0 && phase_q == rcsc_pkg::PH_SKIP && verdict_q == rcsc_pkg::V_NONE,
    "walk state not cleared after the last byte")
  `RCSC_ASSERT_NXT(a_verdict_holds,
    verdict_q != rcsc_pkg::V_NONE && !(proc && last_q),
    $stable(verdict_q) && $stable(nha_q) && $stable(phase_q),
    "latched verdict or walk position changed before the last byte")
  `RCSC_ASSERT_IMM(a_prefix_count,
    phase_q == rcsc_pkg::PH_PREFIX && verdict_q == rcsc_pkg::V_NONE,
    k_q <= 5'd27 && seen_q == (k_q >= 5'd16),
    "ds64 prefix count out of step with the captured data size")

endmodule

FILE: hw/rtl/rcsc_out.sv
// ----------------------------------------------------------------------------
// rcsc_out
// Result register on the master stream side.
// ----------------------------------------------------------------------------
`include "riff_chunk_size_checker_defines.svh"

module rcsc_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcsc_pkg::res_msg_t   res_i,
  output logic                 free_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [7:0]           m_data_o
);

  logic               valid_q;
  rcsc_pkg::result_t  result_q;

  // The slot frees in the same cycle its transfer completes.
  assign free_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.valid) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      result_q <= res_i.result;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = 8'(result_q);

  `RCSC_ASSERT_IMM(a_no_overwrite, res_i.valid, !valid_q || m_ready_i,
    "result register loaded while holding an untaken result")

endmodule

FILE: hw/rtl/riff_chunk_size_checker.sv
// ----------------------------------------------------------------------------
// riff_chunk_size_checker
// RIFF/RF64/BW64 chunk table size check over a byte stream.
// ----------------------------------------------------------------------------
// Write the total file length over APB (register 0, byte address 0) while
// the block is idle, then stream the file one byte per transfer on the slave
// stream, tlast set on the final byte. Every byte moves through an input
// register and one pass of the walk logic, so one byte per cycle is taken
// in steady state. Exactly one result transfer leaves on the master stream
// for each tlast byte: tdata bit 0 says refused, bits 2:1 give the cause.
// The result is registered once the last byte leaves the input register.
// Ordinary bytes never wait on the master side; a last byte waits in the
// input register while an earlier result is still untaken, and then
// s_axis_tready drops until it moves on. Reset clears the walk state and
// sets the file length to zero. After each last byte the walk state returns
// to its reset values and the file length is kept for the next file.
// ----------------------------------------------------------------------------
module riff_chunk_size_checker #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcsc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rcsc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rcsc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // Byte stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] file_byte
  input  logic                             s_axis_tlast,  // last_byte
  // Verdict out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata   // [0] refused, [2:1] cause
);

  logic [rcsc_pkg::CFG_LEN_W-1:0] file_length;
  rcsc_pkg::res_msg_t             res;
  logic                           out_free;

  rcsc_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .file_length_o (file_length)
  );

  rcsc_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .file_length_i (file_length),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_byte_i      (s_axis_tdata),
    .s_last_i      (s_axis_tlast),
    .out_free_i    (out_free),
    .res_o         (res)
  );

  rcsc_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

FILE: bench/chunk_walk_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_walk_monitor
// Watches the configuration port and both streams of the RIFF chunk size
// checker, predicts each verdict from the byte stream and compares it with
// the result transfers.
// ----------------------------------------------------------------------------
module chunk_walk_monitor #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [rcsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rcsc_pkg::APB_DATA_W-1:0]   pwdata,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] file_byte
  input  logic                              s_axis_tlast,  // last_byte
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [7:0]                        m_axis_tdata,  // [0] refused, [2:1] cause
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output logic [3:0]                        causes_seen_o
);

  localparam logic [rcsc_pkg::APB_ADDR_W-1:0] LEN_ADDR =
    {rcsc_pkg::REG_FILE_LENGTH, 3'b000};
  localparam logic [63:0] TABLE_ENTRY = 64'd12;
  localparam logic [63:0] OFFS_MAX = (64'd1 << (OFFSET_BITS + 1)) - 64'd1;

  logic [47:0]          len_reg;
  logic [63:0]          offs;
  logic [63:0]          hdr_at;
  rcsc_pkg::phase_e     phase;
  logic [31:0]          id_word;
  logic [31:0]          size_word;
  logic [63:0]          pfx_word;
  logic [63:0]          ds64_len;
  logic                 ds64_found;
  rcsc_pkg::verdict_e   verdict;

  rcsc_pkg::result_t    verdict_q[$];
  rcsc_pkg::result_t    want;
  rcsc_pkg::result_t    got;
  rcsc_pkg::verdict_e   final_v;
  int unsigned          fails;

  function automatic logic [63:0] cur_len();
    return {16'b0, len_reg} & ((64'd1 << OFFSET_BITS) - 64'd1);
  endfunction

  function automatic rcsc_pkg::cause_e cause_for(rcsc_pkg::verdict_e v);
    case (v)
      rcsc_pkg::V_OVERRUN: return rcsc_pkg::CAUSE_OVERRUN;
      rcsc_pkg::V_TABLE:   return rcsc_pkg::CAUSE_TABLE;
      rcsc_pkg::V_RAGGED:  return rcsc_pkg::CAUSE_RAGGED;
      default:             return rcsc_pkg::CAUSE_OK;
    endcase
  endfunction

  task automatic clear_walk();
    offs       = '0;
    hdr_at     = 64'(rcsc_pkg::HDR_START);
    phase      = rcsc_pkg::PH_SKIP;
    id_word    = '0;
    size_word  = '0;
    pfx_word   = '0;
    ds64_len   = '0;
    ds64_found = 1'b0;
    verdict    = rcsc_pkg::V_NONE;
  endtask

  // Overrun rule at the end of a chunk header (or ds64 prefix), then move on.
  task automatic end_chunk(input logic [63:0] hdr_end, input logic [63:0] declared);
    logic [63:0] l;
    logic [63:0] room;
    logic        past;
    l    = cur_len();
    past = hdr_end > l;
    room = past ? 64'd0 : l - hdr_end;
    if (past || declared > room) begin
      if (id_word != rcsc_pkg::ID_DATA) begin
        verdict = rcsc_pkg::V_OVERRUN;
        return;
      end
      if (!ds64_found || past || ds64_len > room) begin
        verdict = rcsc_pkg::V_OK;
        return;
      end
      declared = ds64_len;
    end
    hdr_at = hdr_end + declared + {63'b0, declared[0]};
    phase  = rcsc_pkg::PH_SKIP;
  endtask

  task automatic walk_byte(input logic [7:0] b);
    logic [63:0] l;
    logic [63:0] k;
    logic [63:0] hdr_end;
    logic [63:0] dec;
    l = cur_len();
    if (phase == rcsc_pkg::PH_SKIP) begin
      if (offs != hdr_at) return;
      if (hdr_at + 64'(rcsc_pkg::HDR_LEN) > l) begin
        verdict = (hdr_at >= l) ? rcsc_pkg::V_OK : rcsc_pkg::V_RAGGED;
        return;
      end
      phase     = rcsc_pkg::PH_HEADER;
      id_word   = '0;
      size_word = '0;
    end
    if (phase == rcsc_pkg::PH_HEADER) begin
      k = offs - hdr_at;
      if (k < 4) id_word = {id_word[23:0], b};
      else size_word = size_word | (32'(b) << (8 * (k - 4)));
      if (k == 7) begin
        hdr_end = offs + 1;
        dec     = {32'b0, size_word};
        if (id_word == rcsc_pkg::ID_DS64 && !ds64_found &&
            dec >= 64'(rcsc_pkg::DS64_PREFIX) && hdr_end <= l && dec <= l - hdr_end) begin
          hdr_at   = hdr_end;
          pfx_word = '0;
          phase    = rcsc_pkg::PH_PREFIX;
        end else begin
          end_chunk(hdr_end, dec);
        end
      end
    end else if (phase == rcsc_pkg::PH_PREFIX) begin
      // Prefix bytes 8..15 hold the data size, bytes 24..27 the table length.
      k = offs - hdr_at;
      if (k >= 8 && k < 16) begin
        pfx_word = pfx_word | (64'(b) << (8 * (k - 8)));
        if (k == 15) begin
          ds64_len   = pfx_word;
          ds64_found = 1'b1;
          pfx_word   = '0;
        end
      end else if (k >= 24 && k < 28) begin
        pfx_word = pfx_word | (64'(b) << (8 * (k - 24)));
        if (k == 27) begin
          dec = {32'b0, size_word};
          if (dec - 64'(rcsc_pkg::DS64_PREFIX) < pfx_word * TABLE_ENTRY)
            verdict = rcsc_pkg::V_TABLE;
          else
            end_chunk(hdr_at, dec);
        end
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [63:0] l;
    if (verdict == rcsc_pkg::V_NONE) walk_byte(b);
    if (offs < OFFS_MAX) offs = offs + 1;
    if (!last) return;
    l       = cur_len();
    final_v = verdict;
    if (l < 64'(rcsc_pkg::HDR_START)) begin
      final_v = rcsc_pkg::V_OK;
    end else if (final_v == rcsc_pkg::V_NONE) begin
      // The stream stopped before the walk decided.
      if (phase == rcsc_pkg::PH_SKIP && hdr_at + 64'(rcsc_pkg::HDR_LEN) > l)
        final_v = (hdr_at >= l) ? rcsc_pkg::V_OK : rcsc_pkg::V_RAGGED;
      else
        final_v = rcsc_pkg::V_OK;
    end
    want.refused = (final_v != rcsc_pkg::V_OK);
    want.cause   = cause_for(final_v);
    verdict_q.insert(verdict_q.size(), want);
    clear_walk();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg = '0;
      clear_walk();
      verdict_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
      causes_seen_o <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
        len_reg = pwdata[47:0];
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = rcsc_pkg::result_t'(m_axis_tdata[2:0]);
        if (verdict_q.size() == 0) begin
          $error("result transfer with no verdict pending: tdata %0h", m_axis_tdata);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          causes_seen_o[want.cause] <= 1'b1;
          if (got.refused !== want.refused) begin
            $error("refused: expected %0d, actual %0d", want.refused, got.refused);
            fails++;
          end
          if (got.cause !== want.cause) begin
            $error("cause: expected %0d, actual %0d", want.cause, got.cause);
            fails++;
          end
          if (m_axis_tdata[7:3] !== 5'b0) begin
            $error("tdata padding: expected 0, actual %0h", m_axis_tdata[7:3]);
            fails++;
          end
        end
      end
      pending_o <= verdict_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RIFF chunk size checker.
// ----------------------------------------------------------------------------
// Streams hand-built and randomly assembled RIFF/RF64 files, with the file
// length set over APB ahead of them, and lets chunk_walk_monitor predict
// and check every verdict. The sender runs in bursts with gaps, the receiver
// stalls on its own pattern and once holds off long enough to back up the
// block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned OFFSET_BITS  = 48;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RAND_BYTES   = 150;
  localparam logic [rcsc_pkg::APB_ADDR_W-1:0] LEN_ADDR =
    {rcsc_pkg::REG_FILE_LENGTH, 3'b000};
  localparam logic [31:0] ID_LIST = 32'h4C49_5354;
  localparam logic [31:0] ID_JUNK = 32'h6A75_6E6B;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [rcsc_pkg::APB_ADDR_W-1:0]  paddr;
  logic [rcsc_pkg::APB_DATA_W-1:0]  pwdata;
  logic [rcsc_pkg::APB_DATA_W-1:0]  prdata;
  logic                             pready;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata;  // [7:0] file_byte
  logic                             s_axis_tlast;  // last_byte
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [7:0]                       m_axis_tdata;  // [0] refused, [2:1] cause

  int unsigned  fail_count;
  int unsigned  pending;
  logic [3:0]   causes_seen;

  stream_byte_t byte_fifo[$];
  logic [7:0]   img[$];
  stream_byte_t nb;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  rx_mode;
  int unsigned  rx_left;
  bit           hold_go;
  int unsigned  bytes_accepted;
  int unsigned  files_queued;
  int unsigned  len_writes;
  int unsigned  rand_bytes;
  int unsigned  full;
  int unsigned  roll;
  bit           with_last;
  logic [47:0]  flen;
  logic [31:0]  hi;
  logic [31:0]  lo;

  riff_chunk_size_checker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  chunk_walk_monitor #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_walk_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .causes_seen_o (causes_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("FAIL riff_chunk_size_checker");
    $finish;
  end

  // Byte sender: bursts of random length separated by random gaps.
  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    burst_left = 1;
    gap_left   = 0;
    bytes_accepted = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) bytes_accepted++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_fifo.size() > 0) begin
          nb = byte_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nb.data;
          s_axis_tlast  <= nb.last;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall pattern changes at random intervals; a hold
  // request blocks it for a long stretch.
  initial begin
    m_axis_tready <= 1'b0;
    rx_mode = 0;
    rx_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(16, 120);
        end
        rx_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Waits until every queued byte has gone and every verdict has been taken,
  // looking just after each edge so the sender's updates are visible.
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (byte_fifo.size() != 0 || s_axis_tvalid || pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [47:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEN_ADDR;
    pwdata  <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    len_writes++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    img.insert(img.size(), b);
  endtask

  // Chunk ids go out first byte most significant, sizes little-endian.
  task automatic put_id(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) append_byte(id[8*i +: 8]);
  endtask

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) append_byte(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) append_byte(8'($urandom));
  endtask

  task automatic queue_file(input bit mark_last);
    stream_byte_t sb;
    for (int i = 0; i < img.size(); i++) begin
      sb.data = img[i];
      sb.last = mark_last && (i == img.size() - 1);
      byte_fifo.insert(byte_fifo.size(), sb);
    end
    img.delete();
    files_queued++;
  endtask

  // A mostly well-formed file: header, often a ds64 chunk, a few chunks,
  // now and then a ragged tail.
  task automatic build_random_file();
    logic [63:0] dlen;
    logic [31:0] decl;
    logic [31:0] w0;
    logic [31:0] w1;
    int          tbl;
    int          dsz;
    int          body;
    int          pick;
    img.delete();
    put_rand(12);
    dlen = 64'($urandom_range(0, 24));
    if ($urandom_range(0, 2) != 0) begin
      tbl = int'($urandom_range(0, 1));
      dsz = 28 + 12 * tbl + int'($urandom_range(0, 3));
      put_id(rcsc_pkg::ID_DS64);
      put_le(64'(dsz), 4);
      put_rand(8);
      if ($urandom_range(0, 7) == 0) begin
        w0 = $urandom;
        w1 = $urandom;
        dlen = {w1, w0};
      end
      put_le(dlen, 8);
      put_rand(8);
      put_le(64'(($urandom_range(0, 5) == 0) ? tbl + 1 : tbl), 4);
      put_rand(dsz - 28);
      if (dsz % 2) put_rand(1);
    end
    repeat ($urandom_range(0, 3)) begin
      pick = int'($urandom_range(0, 3));
      if (pick == 0) begin
        body = (dlen <= 24) ? int'(dlen) : int'($urandom_range(0, 9));
        decl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(body);
        put_id(rcsc_pkg::ID_DATA);
        put_le(64'(decl), 4);
      end else begin
        body = int'($urandom_range(0, 9));
        decl = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(body);
        put_id((pick == 1) ? rcsc_pkg::ID_DS64 : 32'($urandom));
        put_le(64'(decl), 4);
      end
      put_rand(body);
      if (body % 2) put_rand(1);
    end
    if ($urandom_range(0, 5) == 0) put_rand($urandom_range(1, 7));
  endtask

  initial begin
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    hold_go = 1'b0;
    files_queued = 0;
    len_writes = 0;
    rand_bytes = 0;
    @(posedge rst_ni);

    // Files shorter than the RIFF header are always fine.
    settle();
    write_length(48'd0);
    append_byte(8'h00);
    queue_file(1);
    settle();
    write_length(48'd11);
    repeat (11) append_byte(8'hFF);
    queue_file(1);

    // Largest length, stream stops inside the first chunk header.
    settle();
    write_length(48'hFFFF_FFFF_FFFF);
    put_rand(14);
    queue_file(1);

    // Fewer than 8 bytes left after the header: ragged end.
    settle();
    write_length(48'd15);
    put_rand(15);
    queue_file(1);

    // Oversized non-data chunk is refused; oversized data chunk without ds64
    // ends the walk as accepted.
    settle();
    write_length(48'd28);
    put_rand(12);
    put_id(ID_LIST);
    put_le(64'd100, 4);
    put_rand(8);
    queue_file(1);
    put_rand(12);
    put_id(rcsc_pkg::ID_DATA);
    put_le(64'd100, 4);
    put_rand(8);
    queue_file(1);

    // ds64 whose table does not fit in the chunk.
    settle();
    write_length(48'd48);
    put_rand(12);
    put_id(rcsc_pkg::ID_DS64);
    put_le(64'd28, 4);
    put_rand(8);
    put_le(64'd20, 8);
    put_rand(8);
    put_le(64'd1, 4);
    queue_file(1);

    // Data chunk resized from ds64, odd size with pad, then a ragged tail.
    settle();
    write_length(48'd73);
    put_rand(12);
    put_id(rcsc_pkg::ID_DS64);
    put_le(64'd28, 4);
    put_rand(8);
    put_le(64'd5, 8);
    put_rand(8);
    put_le(64'd0, 4);
    put_id(rcsc_pkg::ID_DATA);
    put_le(64'h0000_0000_FFFF_FFFF, 4);
    put_rand(6);
    put_id(ID_LIST);
    put_le(64'd0, 4);
    put_rand(3);
    queue_file(1);

    // Length shrinks in the middle of a chunk header.
    settle();
    write_length(48'd40);
    put_rand(12);
    put_id(ID_JUNK);
    queue_file(0);
    settle();
    write_length(48'd18);
    put_le(64'd4, 4);
    put_rand(4);
    queue_file(1);

    // Stream runs on past the file length.
    settle();
    write_length(48'd12);
    put_rand(24);
    queue_file(1);

    // Back-pressure: many tiny files while the receiver holds off.
    settle();
    write_length(48'd5);
    hold_go = 1'b1;
    repeat (40) begin
      put_rand($urandom_range(1, 4));
      queue_file(1);
    end

    while (rand_bytes < RAND_BYTES) begin
      build_random_file();
      full = img.size();
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        hi = $urandom;
        lo = $urandom;
        flen = {hi[15:0], lo};
      end else if (roll == 1) begin
        flen = 48'(full + $urandom_range(1, 9));
      end else if (roll == 2) begin
        flen = 48'(full - $urandom_range(1, 9));
      end else begin
        flen = 48'(full);
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) repeat ($urandom_range(1, full - 1)) void'(img.pop_back());
      else if (roll == 1) put_rand($urandom_range(1, 10));
      settle();
      write_length(flen);
      rand_bytes += img.size();
      with_last = ($urandom_range(0, 11) != 0);
      queue_file(with_last);
      // Sometimes a second file follows straight away under the same length.
      if ($urandom_range(0, 3) == 0) begin
        build_random_file();
        rand_bytes += img.size();
        queue_file(1);
      end
    end

    settle();
    $display("Run covered %0d files, %0d bytes, %0d length writes and a %0d-cycle hold.",
             files_queued, bytes_accepted, len_writes, HOLD_CYCLES);
    $display("Causes checked (bit per cause, ok lowest): %b", causes_seen);
    if (fail_count == 0) begin
      $display("PASS riff_chunk_size_checker");
    end else begin
      $display("FAIL riff_chunk_size_checker");
    end
    $finish;
  end

endmodule
